[src/stepper_step_dir_pulse_queue_assert.svh]
// Assertion macros used by the step/direction pulse queue core module.
// Depends on nothing; the assertions vanish when SYNTHESIS is defined.
`ifndef STEPPER_STEP_DIR_PULSE_QUEUE_ASSERT_SVH
`define STEPPER_STEP_DIR_PULSE_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define SSPQ_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("sspq assertion failed");
`define SSPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("sspq assertion failed");
`else
`define SSPQ_ASSERT(lbl, clk, rstn, prop)
`define SSPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[src/sspq_pkg.sv]
// Package of the step/direction pulse queue: sizes, codes, reset values and
// the configuration and result types. Depends on nothing.
package sspq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	localparam int STEP_W = 16;
	localparam int TICK_W = 17;
	localparam int SPR_W = 15;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_STEPS = 2'd1;
	localparam logic [1:0] KIND_REVS = 2'd2;
	localparam logic [1:0] KIND_STOP = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_GAP = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV = 8'd1;

	localparam logic [15:0] STEP_GAP_RESET = 16'd1000;
	localparam logic [SPR_W-1:0] STEPS_PER_REV_RESET = 15'd200;

	typedef struct packed {
		logic [15:0] step_gap;
		logic [SPR_W-1:0] steps_per_rev;
	} cfg_t;

	typedef struct packed {
		logic dropped;
		logic [3:0] queued;
		logic queue_empty;
		logic signed [STEP_W-1:0] remaining;
		logic dir_level;
		logic step_level;
	} result_t;

endpackage

[src/sspq_cfg.sv]
// Configuration registers of the step/direction pulse queue.
// Depends on sspq_pkg.
module sspq_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [sspq_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [sspq_pkg::CFG_DATA_W-1:0] cfg_data,
	output sspq_pkg::cfg_t cfg
);

	logic [15:0] step_gap_q;
	logic [sspq_pkg::SPR_W-1:0] steps_per_rev_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_gap_q <= sspq_pkg::STEP_GAP_RESET;
			steps_per_rev_q <= sspq_pkg::STEPS_PER_REV_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == sspq_pkg::REG_STEP_GAP) begin
				step_gap_q <= cfg_data[15:0];
			end else if (cfg_index == sspq_pkg::REG_STEPS_PER_REV) begin
				steps_per_rev_q <= cfg_data[sspq_pkg::SPR_W-1:0];
			end
		end
	end

	assign cfg.step_gap = step_gap_q;
	assign cfg.steps_per_rev = steps_per_rev_q;

endmodule

[src/sspq_core.sv]
// Motion state of the step/direction pulse queue: goal FIFO, step counter,
// pulse timing and flags. Depends on sspq_pkg and the assertion header.
`include "stepper_step_dir_pulse_queue_assert.svh"
module sspq_core (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [1:0] kind,
	input logic signed [sspq_pkg::STEP_W-1:0] amount,
	input sspq_pkg::cfg_t cfg,
	output sspq_pkg::result_t result
);

	localparam int DEPTH = sspq_pkg::QUEUE_DEPTH;
	localparam int IDX_W = sspq_pkg::IDX_W;
	localparam int CNT_W = sspq_pkg::CNT_W;
	localparam int SUM_W = sspq_pkg::SUM_W;
	localparam int STEP_W = sspq_pkg::STEP_W;
	localparam int TICK_W = sspq_pkg::TICK_W;

	logic [STEP_W-1:0] queue_q [DEPTH];
	logic [IDX_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [STEP_W-1:0] steps_q, steps_d;
	logic pulse_q, pulse_d;
	logic dir_q, dir_d;
	logic [TICK_W-1:0] ticks_q, ticks_d, ticks_inc;
	logic empty_q, empty_d;
	logic dropped;
	logic push;
	logic wr_en;
	logic [IDX_W-1:0] tail;
	logic [SUM_W-1:0] tail_sum;
	logic [STEP_W-1:0] product;
	logic [STEP_W-1:0] goal;
	logic full;

	assign full = (count_q == CNT_W'(DEPTH));
	assign product = STEP_W'(amount) * STEP_W'(cfg.steps_per_rev);
	assign goal = (kind == sspq_pkg::KIND_REVS) ? product : amount;
	assign push = (kind == sspq_pkg::KIND_STEPS) || (kind == sspq_pkg::KIND_REVS);
	assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
		: IDX_W'(tail_sum);
	assign ticks_inc = (ticks_q == {TICK_W{1'b1}}) ? ticks_q : ticks_q + 1'b1;

	always_comb begin
		head_d = head_q;
		count_d = count_q;
		steps_d = steps_q;
		pulse_d = pulse_q;
		dir_d = dir_q;
		ticks_d = ticks_q;
		empty_d = empty_q;
		dropped = 1'b0;
		wr_en = 1'b0;
		case (kind)
			sspq_pkg::KIND_TICK: begin
				ticks_d = ticks_inc;
				if (steps_q != '0) begin
					empty_d = 1'b0;
					dir_d = steps_q[STEP_W-1];
					if (ticks_inc > TICK_W'(cfg.step_gap)) begin
						pulse_d = !pulse_q;
						ticks_d = '0;
						if (pulse_q) begin
							steps_d = steps_q[STEP_W-1] ? steps_q + 1'b1 : steps_q - 1'b1;
						end
					end
				end else if (count_q != '0) begin
					steps_d = queue_q[head_q];
					head_d = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
					count_d = count_q - 1'b1;
					empty_d = 1'b0;
				end else begin
					empty_d = 1'b1;
				end
			end
			sspq_pkg::KIND_STEPS, sspq_pkg::KIND_REVS: begin
				if (full) begin
					dropped = 1'b1;
				end else begin
					wr_en = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			sspq_pkg::KIND_STOP: begin
				steps_d = '0;
			end
			default: begin
				steps_d = steps_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			steps_q <= '0;
			pulse_q <= 1'b0;
			dir_q <= 1'b0;
			ticks_q <= '0;
			empty_q <= 1'b1;
		end else if (en) begin
			head_q <= head_d;
			count_q <= count_d;
			steps_q <= steps_d;
			pulse_q <= pulse_d;
			dir_q <= dir_d;
			ticks_q <= ticks_d;
			empty_q <= empty_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en && wr_en) begin
			queue_q[tail] <= goal;
		end
	end

	assign result.step_level = pulse_d;
	assign result.dir_level = dir_d;
	assign result.remaining = steps_d;
	assign result.queue_empty = empty_d;
	assign result.queued = 4'(count_d);
	assign result.dropped = en && push && dropped;

	`SSPQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH))
	`SSPQ_ASSERT(a_empty_idle, clk, arst_n, !empty_q || steps_q == '0)
	`SSPQ_ASSERT(a_edge_restarts, clk, arst_n, !($rose(pulse_q) || $fell(pulse_q)) || ticks_q == '0)
	`SSPQ_ASSERT_NEXT(a_full_drop, clk, arst_n, en && push && full, count_q == CNT_W'(DEPTH) && head_q == $past(head_q))

endmodule

[src/stepper_step_dir_pulse_queue.sv]
// Top level of the step/direction pulse queue: input register, motion core
// and result register. Depends on sspq_pkg, sspq_cfg and sspq_core.
// The input transfer loads the input register; the core result is captured in
// the result register once the output is free and is offered from there.
// Throughput: one item per cycle with the output free; one-pass motion update.
// Reset clears the pipeline, the counters and the flags and loads the
// register defaults; the goal storage keeps no reset.
module stepper_step_dir_pulse_queue (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [15:0] s_tdata, // amount[15:0]
	input logic [1:0] s_tuser, // kind[1:0]
	output logic m_tvalid,
	input logic m_tready,
	// step_level[0], dir_level[1], remaining[17:2], queue_empty[18], queued[22:19],
	// dropped[23]
	output logic [23:0] m_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [sspq_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [sspq_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic valid_s1;
	logic [1:0] kind_s1;
	logic signed [15:0] amount_s1;
	logic valid_s2;
	sspq_pkg::result_t result_s2;
	sspq_pkg::result_t result;
	sspq_pkg::cfg_t cfg;
	logic adv;

	assign adv = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			amount_s1 <= s_tdata;
		end
		if (adv) begin
			result_s2 <= result;
		end
	end

	sspq_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	sspq_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.kind(kind_s1),
		.amount(amount_s1),
		.cfg(cfg),
		.result(result)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata = result_s2;

endmodule
